// ===== src/ssif_pkg.sv =====
package ssif_pkg;

    // Longest block the bus may deliver; longer lengths are clamped to it.
    localparam int unsigned MaxBlockBytes = 32;
    localparam int unsigned LenW          = 6;
    localparam int unsigned PosW          = 6;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    localparam logic [7:0] SEQ_FINAL = 8'hFF;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_BLOCK_DONE = 3'd1;
    localparam logic [2:0] KIND_COMPLETE   = 3'd2;
    localparam logic [2:0] KIND_ORDER      = 3'd3;
    localparam logic [2:0] KIND_TOO_LARGE  = 3'd4;
    localparam logic [2:0] KIND_BUS_ERROR  = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [5:0] block_length;
        logic       first_of_block;
        logic       last_of_block;
        logic       bus_error;
    } ssif_in_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_offset;
        logic [7:0] message_length;
        logic       last;
    } ssif_out_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [1:0]           cnt;
        ssif_out_t [2:0]      res;
    } ssif_bundle_t;

    function automatic ssif_out_t mk_res(input logic [2:0] kind, input logic [7:0] data,
                                         input logic [7:0] off, input logic [7:0] len);
        ssif_out_t r;
        r.result_kind    = kind;
        r.data_byte      = data;
        r.byte_offset    = off;
        r.message_length = len;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/ssif_multipart_read_reassembler_unit.sv =====
// SSIF multipart read reassembler.
// rx channel: one byte of an SMBus block read per item (rx_valid, rx_stall,
// rx_item), with the block length and first/last marks, or a bus error.
// res channel: result items (res_valid, res_stall, res_item): data bytes
// with their message offset, block done, message complete with its length,
// out of order, too large or bus error; last marks the final result of an
// input item. One input item yields zero to three results.
// cfg_we/cfg_wdata write the buffer capacity; write it only while idle.
// The front decodes a byte in the cycle it is taken and queues its results
// in a four-entry queue; the back plays them out one per cycle unless stalled.
// A byte's results are registered in the queue, then in the back's cur_reg.
// Throughput: one byte per cycle while results keep pace; the output side
// delivers one result per cycle, so bytes giving several results throttle it.
// A stalled receiver holds the current result; bytes are still taken until
// the queue fills, then rx_stall rises.
// Reset empties the queue, sets the capacity to 255 and awaits a first read.
module ssif_multipart_read_reassembler_unit
    import ssif_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    output logic      rx_stall,
    input  ssif_in_t  rx_item,
    output logic      res_valid,
    input  logic      res_stall,
    output ssif_out_t res_item,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic         accept;
    logic         push;
    logic         full;
    logic         pop;
    logic         empty;
    ssif_bundle_t push_data;
    ssif_bundle_t head;

    assign rx_stall = full;
    assign accept   = rx_valid && !full;

    ssif_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (rx_item),
        .push      (push),
        .bundle    (push_data)
    );

    ssif_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    ssif_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

// ===== src/ssif_front.sv =====
module ssif_front
    import ssif_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         accept,
    input  ssif_in_t     item,
    output logic         push,
    output ssif_bundle_t bundle
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HELD    = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    logic [7:0]      cap_reg;
    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      off_reg, off_next;
    logic [7:0]      seq_reg, seq_next;
    logic            final_reg, final_next;
    logic            mp_reg, mp_next;

    always_comb
    begin
        logic [LenW-1:0] len;
        logic [1:0]      cnt;
        logic [8:0]      sum;
        logic [LenW-1:0] size;
        ssif_bundle_t    b;
        logic [7:0]      rb;

        phase_next = phase_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        off_next   = off_reg;
        seq_next   = seq_reg;
        final_next = final_reg;
        mp_next    = mp_reg;
        cnt        = 2'd0;
        b          = '0;
        sum        = '0;
        size       = '0;
        rb         = item.rx_byte;

        len = item.block_length;
        if (len == '0)
            len = LenW'(1);
        else if (len > LenW'(MaxBlockBytes))
            len = LenW'(MaxBlockBytes);

        if (item.bus_error)
        begin
            b.res[cnt] = mk_res(KIND_BUS_ERROR, 8'd0, 8'd0, 8'd0);
            cnt = cnt + 2'd1;
            pos_next = '0; off_next = '0; seq_next = '0; final_next = 1'b0; mp_next = 1'b0;
            phase_next = PH_IDLE;
        end
        else if (item.first_of_block)
        begin
            if (phase_reg != PH_IDLE)
            begin
                pos_next = '0; off_next = '0; seq_next = '0;
                final_next = 1'b0; mp_next = 1'b0;
            end
            phase_next = PH_IDLE;
            pos_next   = PosW'(1);
            if (mp_next)
            begin
                size = len - LenW'(1);
                sum  = {1'b0, off_next} + 9'(size);
                if (rb != SEQ_FINAL && {1'b0, rb} != {1'b0, seq_next} + 9'd1)
                begin
                    b.res[cnt] = mk_res(KIND_ORDER, 8'd0, 8'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    pos_next = '0; off_next = '0; seq_next = '0;
                    final_next = 1'b0; mp_next = 1'b0;
                    phase_next = item.last_of_block ? PH_IDLE : PH_DISCARD;
                end
                else if (sum > {1'b0, cap_reg})
                begin
                    b.res[cnt] = mk_res(KIND_TOO_LARGE, 8'd0, 8'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    pos_next = '0; off_next = '0; seq_next = '0;
                    final_next = 1'b0; mp_next = 1'b0;
                    phase_next = item.last_of_block ? PH_IDLE : PH_DISCARD;
                end
                else
                begin
                    if (rb == SEQ_FINAL)
                        final_next = 1'b1;
                    else
                        seq_next = rb;
                    phase_next = PH_BODY;
                end
            end
            else
            begin
                held_next = rb;
                if (item.last_of_block || len == LenW'(1))
                begin
                    if (cap_reg == 8'd0)
                    begin
                        b.res[cnt] = mk_res(KIND_TOO_LARGE, 8'd0, 8'd0, 8'd0);
                        cnt = cnt + 2'd1;
                        pos_next = '0; off_next = '0; seq_next = '0;
                        final_next = 1'b0; mp_next = 1'b0;
                        phase_next = item.last_of_block ? PH_IDLE : PH_DISCARD;
                    end
                    else
                    begin
                        b.res[cnt] = mk_res(KIND_DATA, rb, off_next, 8'd0);
                        cnt = cnt + 2'd1;
                        off_next = off_next + 8'd1;
                        final_next = 1'b1;
                        phase_next = PH_BODY;
                    end
                end
                else
                    phase_next = PH_HELD;
            end
        end
        else if (phase_reg == PH_DISCARD)
        begin
            if (item.last_of_block)
                phase_next = PH_IDLE;
        end
        else if (phase_reg == PH_HELD)
        begin
            pos_next = PosW'(2);
            if (held_reg == 8'd0 && rb == 8'd1)
            begin
                size = (len >= LenW'(2)) ? len - LenW'(2) : '0;
                if ({2'b00, size} > cap_reg)
                begin
                    b.res[cnt] = mk_res(KIND_TOO_LARGE, 8'd0, 8'd0, 8'd0);
                    cnt = cnt + 2'd1;
                    pos_next = '0; off_next = '0; seq_next = '0;
                    final_next = 1'b0; mp_next = 1'b0;
                    phase_next = item.last_of_block ? PH_IDLE : PH_DISCARD;
                end
                else
                begin
                    mp_next    = 1'b1;
                    seq_next   = '0;
                    final_next = 1'b0;
                    phase_next = PH_BODY;
                end
            end
            else if ({2'b00, len} > cap_reg)
            begin
                b.res[cnt] = mk_res(KIND_TOO_LARGE, 8'd0, 8'd0, 8'd0);
                cnt = cnt + 2'd1;
                pos_next = '0; off_next = '0; seq_next = '0;
                final_next = 1'b0; mp_next = 1'b0;
                phase_next = item.last_of_block ? PH_IDLE : PH_DISCARD;
            end
            else
            begin
                b.res[cnt] = mk_res(KIND_DATA, held_reg, off_next, 8'd0);
                cnt = cnt + 2'd1;
                off_next = off_next + 8'd1;
                if (len > LenW'(1))
                begin
                    b.res[cnt] = mk_res(KIND_DATA, rb, off_next, 8'd0);
                    cnt = cnt + 2'd1;
                    off_next = off_next + 8'd1;
                end
                final_next = 1'b1;
                phase_next = PH_BODY;
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            // drop bytes past the block length or past the largest offset
            if (pos_reg < len && off_reg != 8'hFF)
            begin
                b.res[cnt] = mk_res(KIND_DATA, rb, off_next, 8'd0);
                cnt = cnt + 2'd1;
                off_next = off_next + 8'd1;
            end
            if (pos_reg != '1)
                pos_next = pos_reg + PosW'(1);
        end

        // close the block when its last byte arrives in a good state
        if (!item.bus_error && item.last_of_block && phase_next == PH_BODY
            && (item.first_of_block || phase_reg != PH_DISCARD))
        begin
            if (final_next)
            begin
                b.res[cnt] = mk_res(KIND_COMPLETE, 8'd0, 8'd0, off_next);
                cnt = cnt + 2'd1;
                pos_next = '0; off_next = '0; seq_next = '0;
                final_next = 1'b0; mp_next = 1'b0;
            end
            else
            begin
                b.res[cnt] = mk_res(KIND_BLOCK_DONE, 8'd0, 8'd0, 8'd0);
                cnt = cnt + 2'd1;
                pos_next = '0;
            end
            phase_next = PH_IDLE;
        end

        if (cnt != 2'd0)
            b.res[cnt - 2'd1].last = 1'b1;
        b.cnt  = cnt;
        bundle = b;
    end

    assign push = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 8'hFF;
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            off_reg   <= '0;
            seq_reg   <= '0;
            final_reg <= 1'b0;
            mp_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                off_reg   <= off_next;
                seq_reg   <= seq_next;
                final_reg <= final_next;
                mp_reg    <= mp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

// ===== src/ssif_fifo.sv =====
module ssif_fifo
    import ssif_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ssif_bundle_t push_data,
    output logic         full,
    input  logic         pop,
    output ssif_bundle_t pop_data,
    output logic         empty
);

    ssif_bundle_t      mem_reg [QDepth];
    logic [QAw-1:0]    wr_reg, wr_next;
    logic [QAw-1:0]    rd_reg, rd_next;
    logic [QAw:0]      cnt_reg, cnt_next;

    assign full     = (cnt_reg == (QAw+1)'(QDepth));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + QAw'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + QAw'(1) : rd_reg;
        cnt_next = cnt_reg + (QAw+1)'(push) - (QAw+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

// ===== src/ssif_back.sv =====
module ssif_back
    import ssif_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         empty,
    input  ssif_bundle_t head,
    output logic         pop,
    output logic         res_valid,
    input  logic         res_stall,
    output ssif_out_t    res_item
);

    ssif_bundle_t cur_reg;
    logic         have_reg;
    logic [1:0]   idx_reg;
    logic         take;
    logic         at_end;

    assign res_valid = have_reg;
    assign res_item  = cur_reg.res[idx_reg];
    assign take      = have_reg && !res_stall;
    assign at_end    = (idx_reg == cur_reg.cnt - 2'd1);
    // refill when no bundle is held or as the current bundle's final result leaves
    assign pop       = !empty && (!have_reg || (take && at_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            have_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            if (at_end)
                have_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
    end

endmodule

// ===== test/ssif_reassembly_checker.sv =====
`timescale 1ns / 100ps

module ssif_reassembly_checker
    import ssif_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_stall,
    input  ssif_in_t   rx_item,
    input  logic       res_valid,
    input  logic       res_stall,
    input  ssif_out_t  res_item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         mismatch_count,
    output int         outstanding
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HELD,
        PH_BODY,
        PH_DISCARD
    } read_phase_t;

    logic [7:0]  capacity;
    read_phase_t phase;
    logic [7:0]  held_byte;
    logic [7:0]  pos_in_block;
    logic [7:0]  msg_offset;
    logic [7:0]  last_seq;
    logic        final_seen;
    logic        multipart;

    ssif_out_t   step_results[$];
    ssif_out_t   awaited_results[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic note(input logic [2:0] kind, input logic [7:0] data,
                        input logic [7:0] off, input logic [7:0] len);
        ssif_out_t r;
        r.result_kind    = kind;
        r.data_byte      = data;
        r.byte_offset    = off;
        r.message_length = len;
        r.last           = 1'b0;
        if (step_results.size() < 3)
            step_results.push_back(r);
    endtask

    task automatic drop_message();
        pos_in_block = '0;
        msg_offset   = '0;
        last_seq     = '0;
        final_seen   = 1'b0;
        multipart    = 1'b0;
    endtask

    task automatic abort_read(input logic [2:0] kind, input logic at_end);
        note(kind, '0, '0, '0);
        drop_message();
        phase = at_end ? PH_IDLE : PH_DISCARD;
    endtask

    task automatic give_data(input logic [7:0] b);
        note(KIND_DATA, b, msg_offset, '0);
        msg_offset = msg_offset + 8'd1;
    endtask

    task automatic close_block();
        if (final_seen) begin
            note(KIND_COMPLETE, '0, '0, msg_offset);
            drop_message();
        end
        else begin
            note(KIND_BLOCK_DONE, '0, '0, '0);
            pos_in_block = '0;
        end
        phase = PH_IDLE;
    endtask

    // Work out the results one byte causes and queue them behind the older ones.
    task automatic reassemble_byte(input ssif_in_t it);
        int unsigned len;
        int unsigned size;
        logic [7:0]  b;
        logic        lst;

        step_results.delete();
        b   = it.rx_byte;
        lst = it.last_of_block;
        len = it.block_length;
        if (len == 0)
            len = 1;
        if (len > MaxBlockBytes)
            len = MaxBlockBytes;

        if (it.bus_error) begin
            abort_read(KIND_BUS_ERROR, 1'b1);
        end
        else if (it.first_of_block) begin
            if (phase != PH_IDLE)
                drop_message();
            phase        = PH_IDLE;
            pos_in_block = 8'd1;
            if (multipart) begin
                size = len - 1;
                if (b != SEQ_FINAL && int'(b) != int'(last_seq) + 1) begin
                    abort_read(KIND_ORDER, lst);
                end
                else if (int'(msg_offset) + size > int'(capacity)) begin
                    abort_read(KIND_TOO_LARGE, lst);
                end
                else begin
                    if (b == SEQ_FINAL)
                        final_seen = 1'b1;
                    else
                        last_seq = b;
                    phase = PH_BODY;
                    if (lst)
                        close_block();
                end
            end
            else begin
                held_byte = b;
                if (lst || len == 1) begin
                    if (capacity < 8'd1) begin
                        abort_read(KIND_TOO_LARGE, lst);
                    end
                    else begin
                        give_data(b);
                        final_seen = 1'b1;
                        phase      = PH_BODY;
                        if (lst)
                            close_block();
                    end
                end
                else begin
                    phase = PH_HELD;
                end
            end
        end
        else if (phase == PH_DISCARD) begin
            if (lst)
                phase = PH_IDLE;
        end
        else if (phase == PH_HELD) begin
            pos_in_block = 8'd2;
            if (held_byte == 8'h00 && b == 8'h01) begin
                size = (len >= 2) ? len - 2 : 0;
                if (size > capacity) begin
                    abort_read(KIND_TOO_LARGE, lst);
                end
                else begin
                    multipart  = 1'b1;
                    last_seq   = '0;
                    final_seen = 1'b0;
                    phase      = PH_BODY;
                    if (lst)
                        close_block();
                end
            end
            else if (len > capacity) begin
                abort_read(KIND_TOO_LARGE, lst);
            end
            else begin
                give_data(held_byte);
                if (len > 1)
                    give_data(b);
                final_seen = 1'b1;
                phase      = PH_BODY;
                if (lst)
                    close_block();
            end
        end
        else if (phase == PH_BODY) begin
            if (pos_in_block < len && msg_offset < 8'd255)
                give_data(b);
            if (pos_in_block < 8'd255)
                pos_in_block = pos_in_block + 8'd1;
            if (lst)
                close_block();
        end

        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
    endtask

    task automatic check_result(input ssif_out_t got);
        ssif_out_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("with nothing awaited, kind", got.result_kind, -1);
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch("kind", got.result_kind, want.result_kind);
        if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
        if (got.message_length !== want.message_length)
            report_mismatch("message_length", got.message_length, want.message_length);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity  = 8'd255;
            phase     = PH_IDLE;
            held_byte = '0;
            drop_message();
            awaited_results.delete();
            mismatch_count = 0;
            outstanding   <= 0;
        end
        else begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (rx_valid && !rx_stall)
                reassemble_byte(rx_item);
            if (res_valid && !res_stall)
                check_result(res_item);
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ===== test/ssif_multipart_read_reassembler_unit_test.sv =====
`timescale 1ns / 100ps

module ssif_multipart_read_reassembler_unit_test;
    import ssif_pkg::*;

    localparam int RandomItems = 250;
    localparam int Drain       = 16;
    localparam int CycleLimit  = 400000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic       rx_stall;
    ssif_in_t   rx_item   = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    ssif_out_t  res_item;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;

    int         mismatch_count;
    int         outstanding;
    int         items_sent = 0;
    int         cycles     = 0;
    bit         src_burst  = 1'b0;
    bit         sink_burst = 1'b0;
    int         sink_wait  = 0;
    logic [7:0] block_bytes[$];

    always #4 clk = ~clk;

    ssif_multipart_read_reassembler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ssif_reassembly_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_item        (rx_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Result side: hold off a random number of cycles after each item taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            sink_wait  = 0;
        end
        else begin
            if (res_valid && !res_stall) begin
                if ($urandom_range(0, 24) == 0)
                    sink_burst = !sink_burst;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 10);
            end
            else if (sink_wait != 0) begin
                sink_wait--;
            end
            res_stall <= (sink_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_item(input ssif_in_t it, input bit counted);
        int gap;
        if ($urandom_range(0, 24) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_item  <= it;
        rx_valid <= 1'b1;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    // Send the first n_send bytes of block_bytes as one block.
    task automatic send_block(input logic [5:0] len_field, input int n_send, input bit close);
        ssif_in_t it;
        for (int i = 0; i < n_send; i++) begin
            it.rx_byte        = block_bytes[i];
            it.block_length   = len_field;
            it.first_of_block = (i == 0);
            it.last_of_block  = close && (i == n_send - 1);
            it.bus_error      = 1'b0;
            push_item(it, 1'b1);
        end
    endtask

    task automatic send_bus_error(input bit all_ones);
        logic [31:0] r;
        ssif_in_t    it;
        r            = all_ones ? '1 : $urandom;
        it           = r[16:0];
        it.bus_error = 1'b1;
        push_item(it, 1'b1);
    endtask

    // Drain: hold the sender until every awaited result has come back.
    task automatic settle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (Drain) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [7:0] cap);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int data_size(input int most);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(most - 3, most);
        return $urandom_range(0, 6);
    endfunction

    task automatic multipart_read();
        int n_mid;
        int fault;
        int fault_at;
        int sz;
        int n_send;
        n_mid    = $urandom_range(0, 3);
        fault    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        fault_at = $urandom_range(0, n_mid + 1);
        for (int b = 0; b <= n_mid + 1; b++) begin
            block_bytes.delete();
            if (b == 0) begin
                block_bytes.push_back(8'h00);
                block_bytes.push_back(8'h01);
                sz = data_size(30);
            end
            else begin
                block_bytes.push_back((b == n_mid + 1) ? SEQ_FINAL : 8'(b));
                sz = data_size(31);
            end
            repeat (sz) block_bytes.push_back(8'($urandom));
            if (fault != 0 && b == fault_at) begin
                if (fault == 1) begin
                    // wrong sequence number, or no marker on the first block
                    if (b == 0)
                        block_bytes[1] = 8'($urandom_range(2, 255));
                    else
                        block_bytes[0] = 8'(b + 1 + $urandom_range(0, 100));
                    send_block(6'(block_bytes.size()), block_bytes.size(), 1'b1);
                    return;
                end
                n_send = $urandom_range(0, block_bytes.size() - 1);
                send_block(6'(block_bytes.size()), n_send, 1'b0);
                if (fault == 2)
                    send_bus_error(1'b0);
                return;
            end
            send_block(6'(block_bytes.size()), block_bytes.size(), 1'b1);
        end
    endtask

    task automatic single_read();
        int n;
        n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 12);
        block_bytes.delete();
        repeat (n) block_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0)
            block_bytes[0] = 8'h00;
        if (n > 1 && block_bytes[0] == 8'h00 && block_bytes[1] == 8'h01)
            block_bytes[1] = 8'h02;
        send_block(6'(n), n, 1'b1);
    endtask

    // Length field anywhere in its range, with short blocks and bytes past the length.
    task automatic odd_block();
        logic [5:0] len_field;
        int         eff;
        int         n;
        len_field = 6'($urandom);
        eff = (len_field == 0) ? 1 : ((len_field > MaxBlockBytes) ? MaxBlockBytes : len_field);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : eff + $urandom_range(0, 2);
        block_bytes.delete();
        repeat (n) block_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) begin
            block_bytes[0] = 8'h00;
            if (n > 1)
                block_bytes[1] = 8'h01;
        end
        send_block(len_field, n, $urandom_range(0, 4) != 0);
    endtask

    task automatic stray_bytes();
        logic [31:0] r;
        ssif_in_t    it;
        repeat ($urandom_range(1, 3)) begin
            r                 = $urandom;
            it                = r[16:0];
            it.first_of_block = 1'b0;
            it.bus_error      = 1'b0;
            push_item(it, 1'b0);
        end
    endtask

    task automatic random_read();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            multipart_read();
        else if (pick < 70)
            single_read();
        else if (pick < 82)
            odd_block();
        else if (pick < 90)
            stray_bytes();
        else if (pick < 96)
            send_bus_error(1'b0);
        else
            settle();
    endtask

    initial
    begin
        ssif_in_t   it;
        logic [7:0] cap;
        int         goal;
        int         base;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // byte with no block open: ignored
        it = '{rx_byte: 8'h3C, block_length: 6'd5, first_of_block: 1'b0,
               last_of_block: 1'b0, bus_error: 1'b0};
        push_item(it, 1'b0);
        // one-byte first block
        block_bytes = '{8'hFF};
        send_block(6'd1, 1, 1'b1);
        // single-part message that opens with zero
        block_bytes = '{8'h00, 8'h7F, 8'hA5};
        send_block(6'd3, 3, 1'b1);
        // clean three-block multipart read
        block_bytes = '{8'h00, 8'h01, 8'h11};
        send_block(6'd3, 3, 1'b1);
        block_bytes = '{8'h01, 8'h22};
        send_block(6'd2, 2, 1'b1);
        block_bytes = '{SEQ_FINAL, 8'h33};
        send_block(6'd2, 2, 1'b1);
        // out-of-order continuation
        block_bytes = '{8'h00, 8'h01};
        send_block(6'd2, 2, 1'b1);
        block_bytes = '{8'h05, 8'h44};
        send_block(6'd2, 2, 1'b1);
        // bus error inside a block
        block_bytes = '{8'h10, 8'h20, 8'h30, 8'h40};
        send_block(6'd4, 2, 1'b0);
        send_bus_error(1'b1);
        // new block abandons an open one; zero length counts as one
        block_bytes = '{8'hAB, 8'hCD, 8'hEF};
        send_block(6'd3, 2, 1'b0);
        block_bytes = '{8'h5A};
        send_block(6'd0, 1, 1'b1);
        // oversized length field, then bytes past the length
        block_bytes = '{8'hC3, 8'h3C};
        send_block(6'd63, 2, 1'b1);
        block_bytes = '{8'h01, 8'h02, 8'h03};
        send_block(6'd2, 3, 1'b1);

        base = items_sent;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       cap = 8'd255;
                1:       cap = 8'd0;
                2:       cap = 8'($urandom_range(2, 40));
                3:       cap = 8'd1;
                4:       cap = 8'($urandom);
                default: cap = 8'd255;
            endcase
            set_capacity(cap);
            goal = base + RandomItems * (p + 1) / 6;
            while (items_sent < goal)
                random_read();
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== ssif_multipart_read_reassembler_unit.f =====
src/ssif_pkg.sv
src/ssif_front.sv
src/ssif_fifo.sv
src/ssif_back.sv
src/ssif_multipart_read_reassembler_unit.sv
test/ssif_reassembly_checker.sv
test/ssif_multipart_read_reassembler_unit_test.sv
